### src/isso_pkg.sv
// Package: shared types and constants for the two-set store.
`timescale 1ns / 1ps
package isso_pkg;
  localparam int DefaultCapacity = 16;
  localparam int ValueWidth = 32;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_UNION  = 3'd2,
    REQ_INTER  = 3'd3,
    REQ_DIFF   = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_DELETED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_ELEMENT  = 3'd5,
    ST_EMPTY    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_A,
    S_SCAN_B,
    S_EMIT_EMPTY
  } state_t;

  // Per-cycle command from the sequencer to the cells of one set.
  typedef struct packed {
    logic                  append;
    logic                  remove;
    logic                  rotate;
    logic [ValueWidth-1:0] data;
  } cell_cmd_t;
endpackage

### src/isso_cell.sv
// One storage cell: holds an entry and compares it against a probe value.
`timescale 1ns / 1ps
module isso_cell (
  input  logic                            clk,
  input  isso_pkg::cell_cmd_t             cmd,
  input  logic                            is_tail,
  input  logic                            at_or_after_hit,
  input  logic [isso_pkg::ValueWidth-1:0] from_right,
  input  logic [isso_pkg::ValueWidth-1:0] from_left,
  input  logic [isso_pkg::ValueWidth-1:0] probe,
  input  logic                            valid,
  output logic [isso_pkg::ValueWidth-1:0] entry,
  output logic                            match
);
  // Match only for occupied cells
  assign match = valid && (entry == probe);

  // Shift, append or rotate
  always_ff @(posedge clk) begin
    if (cmd.rotate) begin
      entry <= from_right;
    end else if (cmd.append && is_tail) begin
      entry <= cmd.data;
    end else if (cmd.remove && at_or_after_hit) begin
      entry <= from_left;
    end
  end
endmodule

### src/isso_chain.sv
// A chain of cells holding one set, with a count register.
`timescale 1ns / 1ps
module isso_chain #(
  parameter int Capacity = isso_pkg::DefaultCapacity,
  localparam int CntW = $clog2(Capacity + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  isso_pkg::cell_cmd_t             cmd,
  input  logic [isso_pkg::ValueWidth-1:0] probe,
  output logic [isso_pkg::ValueWidth-1:0] head,
  output logic                            hit,
  output logic [CntW-1:0]                 count
);
  logic [Capacity-1:0]                            match;
  logic [Capacity-1:0]                            after;
  logic [Capacity-1:0][isso_pkg::ValueWidth-1:0] entry;

  assign hit = |match;
  assign head = entry[0];

  // Cells at or after the first hit shift down on delete
  always_comb begin
    after[0] = match[0];
    for (int i = 1; i < Capacity; i++) begin
      after[i] = after[i-1] | match[i];
    end
  end

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [isso_pkg::ValueWidth-1:0] right_v;
    logic [isso_pkg::ValueWidth-1:0] left_v;
    logic                            tail;
    // Rotation wraps at the occupied length
    assign right_v = (CntW'(i + 1) == count) ? entry[0]
                   : entry[(i + 1) % Capacity];
    assign left_v  = entry[(i + 1) % Capacity];
    assign tail    = (CntW'(i) == count);
    isso_cell u_cell (
      .clk             (clk),
      .cmd             (cmd),
      .is_tail         (tail),
      .at_or_after_hit (after[i]),
      .from_right      (right_v),
      .from_left       (left_v),
      .probe           (probe),
      .valid           (CntW'(i) < count),
      .entry           (entry[i]),
      .match           (match[i])
    );
  end

  // Count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.append) begin
      count <= count + 1'b1;
    end else if (cmd.remove) begin
      count <= count - 1'b1;
    end
  end
endmodule

### src/integer_set_store_with_set_ops.sv
// Top level: two-set store with union, intersection and difference.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_ready carries req_type, set_sel, value.
//   Output channel out_valid/out_ready carries status, element, last.
//   Each set is a chain of CAPACITY cells; every cell compares its entry
//   with a probe in parallel, so insert and delete each give one
//   transaction with last set, valid the cycle after acceptance.
//   Set operations rotate set A through its chain, one entry per cycle
//   while the output slot is free, each probed against B; union then
//   rotates B probed against A. The next request is taken once the
//   operation has returned to idle.
//   Taken elements go out one behind through a hold register so that the
//   final one can carry last.
//   One request is worked on at a time.
//   Results sit in an output register; while the receiver stalls the
//   rotation pauses and nothing is lost.
//   Reset empties both sets; entry contents need no clearing.
//   Request codes 5 to 7 are accepted and dropped.
module integer_set_store_with_set_ops #(
  parameter int CAPACITY = isso_pkg::DefaultCapacity,
  localparam int CntW = $clog2(CAPACITY + 1)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic        set_sel,
  input  logic signed [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic signed [31:0] element,
  output logic        last
);
  isso_pkg::state_t    state, state_next;
  isso_pkg::cell_cmd_t cmd_a, cmd_b;
  logic [31:0]         head_a, head_b, probe_a, probe_b;
  logic                hit_a, hit_b;
  logic [CntW-1:0]     cnt_a, cnt_b, idx, idx_next;
  logic [2:0]          op, op_next;
  logic                load;
  logic [2:0]          st_next;
  logic [31:0]         el_next;
  logic                last_next;
  logic                slot_free;
  logic                hold_v, hold_v_next;
  logic [31:0]         hold_el, hold_el_next;

  assign slot_free = !out_valid || out_ready;

  isso_chain #(.Capacity(CAPACITY)) u_a (
    .clk(clk), .rst(rst), .cmd(cmd_a), .probe(probe_a),
    .head(head_a), .hit(hit_a), .count(cnt_a));
  isso_chain #(.Capacity(CAPACITY)) u_b (
    .clk(clk), .rst(rst), .cmd(cmd_b), .probe(probe_b),
    .head(head_b), .hit(hit_b), .count(cnt_b));

  // Probes: during scans each head is checked against the other set
  assign probe_a = (state == isso_pkg::S_SCAN_B) ? head_b : value;
  assign probe_b = (state == isso_pkg::S_SCAN_A) ? head_a : value;

  // Sequencer
  always_comb begin
    logic sel_hit;
    logic [CntW-1:0] sel_cnt;
    logic take;
    state_next   = state;
    idx_next     = idx;
    op_next      = op;
    hold_v_next  = hold_v;
    hold_el_next = hold_el;
    in_ready     = 1'b0;
    load         = 1'b0;
    st_next      = isso_pkg::ST_ELEMENT;
    el_next      = value;
    last_next    = 1'b1;
    cmd_a        = '{append: 1'b0, remove: 1'b0, rotate: 1'b0, data: value};
    cmd_b        = '{append: 1'b0, remove: 1'b0, rotate: 1'b0, data: value};
    sel_hit      = set_sel ? hit_b : hit_a;
    sel_cnt      = set_sel ? cnt_b : cnt_a;
    take         = 1'b0;
    unique case (state)
      isso_pkg::S_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          priority if (req_type == isso_pkg::REQ_INSERT) begin
            load = 1'b1;
            if (sel_hit) begin
              st_next = isso_pkg::ST_PRESENT;
            end else if (sel_cnt == CntW'(CAPACITY)) begin
              st_next = isso_pkg::ST_FULL;
            end else begin
              st_next = isso_pkg::ST_INSERTED;
              if (set_sel) cmd_b.append = 1'b1;
              else         cmd_a.append = 1'b1;
            end
          end else if (req_type == isso_pkg::REQ_DELETE) begin
            load = 1'b1;
            if (sel_hit) begin
              st_next = isso_pkg::ST_DELETED;
              if (set_sel) cmd_b.remove = 1'b1;
              else         cmd_a.remove = 1'b1;
            end else begin
              st_next = isso_pkg::ST_NOTFOUND;
            end
          end else if (req_type == isso_pkg::REQ_UNION ||
                       req_type == isso_pkg::REQ_INTER ||
                       req_type == isso_pkg::REQ_DIFF) begin
            op_next     = req_type;
            hold_v_next = 1'b0;
            idx_next    = '0;
            state_next  = isso_pkg::S_SCAN_A;
          end else begin
            state_next = isso_pkg::S_IDLE;
          end
        end
      end
      isso_pkg::S_SCAN_A: begin
        if (idx == cnt_a) begin
          if (op == isso_pkg::REQ_UNION) begin
            idx_next   = '0;
            state_next = isso_pkg::S_SCAN_B;
          end else if (!hold_v) begin
            state_next = isso_pkg::S_EMIT_EMPTY;
          end else if (slot_free) begin
            // flush the held element as the final one
            load        = 1'b1;
            el_next     = hold_el;
            last_next   = 1'b1;
            hold_v_next = 1'b0;
            state_next  = isso_pkg::S_IDLE;
          end
        end else if (slot_free) begin
          take = (op == isso_pkg::REQ_UNION) ||
                 (op == isso_pkg::REQ_INTER && hit_b) ||
                 (op == isso_pkg::REQ_DIFF && !hit_b);
          cmd_a.rotate = 1'b1;
          idx_next     = idx + 1'b1;
          if (take) begin
            load         = hold_v;
            el_next      = hold_el;
            last_next    = 1'b0;
            hold_v_next  = 1'b1;
            hold_el_next = head_a;
          end
        end
      end
      isso_pkg::S_SCAN_B: begin
        if (idx == cnt_b) begin
          if (!hold_v) begin
            state_next = isso_pkg::S_EMIT_EMPTY;
          end else if (slot_free) begin
            load        = 1'b1;
            el_next     = hold_el;
            last_next   = 1'b1;
            hold_v_next = 1'b0;
            state_next  = isso_pkg::S_IDLE;
          end
        end else if (slot_free) begin
          take         = !hit_a;
          cmd_b.rotate = 1'b1;
          idx_next     = idx + 1'b1;
          if (take) begin
            load         = hold_v;
            el_next      = hold_el;
            last_next    = 1'b0;
            hold_v_next  = 1'b1;
            hold_el_next = head_b;
          end
        end
      end
      isso_pkg::S_EMIT_EMPTY: begin
        if (slot_free) begin
          load       = 1'b1;
          st_next    = isso_pkg::ST_EMPTY;
          el_next    = '0;
          state_next = isso_pkg::S_IDLE;
        end
      end
      default: state_next = isso_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= isso_pkg::S_IDLE;
      idx     <= '0;
      op      <= isso_pkg::REQ_UNION;
      hold_v  <= 1'b0;
      hold_el <= '0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      op      <= op_next;
      hold_v  <= hold_v_next;
      hold_el <= hold_el_next;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      status  <= st_next;
      element <= el_next;
      last    <= last_next;
    end
  end

  // Assertions
  a_cnt_a: assert property (@(posedge clk) disable iff (rst)
    cnt_a <= CntW'(CAPACITY)) else $error("count A overflow");
  a_cnt_b: assert property (@(posedge clk) disable iff (rst)
    cnt_b <= CntW'(CAPACITY)) else $error("count B overflow");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == isso_pkg::S_IDLE) else $error("ready outside idle");
  a_no_dual: assert property (@(posedge clk) disable iff (rst)
    !(cmd_a.append && cmd_a.remove)) else $error("append and remove together");
endmodule

### sim/isso_checker.sv
// Checker: predicts set store results from observed requests and compares them.
`timescale 1ns / 1ps
module isso_checker #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic               set_sel,
  input  logic signed [31:0] value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         status,
  input  logic signed [31:0] element,
  input  logic               last,
  output int                 fail_count,
  output int                 pending
);
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] element;
    logic        last;
  } result_t;

  logic [31:0] mirror_a [CAPACITY];
  logic [31:0] mirror_b [CAPACITY];
  int          cnt_a;
  int          cnt_b;
  result_t     want_q [$];

  assign pending = want_q.size();

  function automatic bit in_a(logic [31:0] v);
    for (int i = 0; i < cnt_a; i++) if (mirror_a[i] == v) return 1;
    return 0;
  endfunction

  function automatic bit in_b(logic [31:0] v);
    for (int i = 0; i < cnt_b; i++) if (mirror_b[i] == v) return 1;
    return 0;
  endfunction

  // Update mirrored sets and queue expected results for one request.
  task automatic predict_request(logic [2:0] rq, logic sel, logic [31:0] v);
    int      pos;
    int      n;
    bit      inb;
    result_t r;
    pos = -1;
    n = 0;
    if (rq == isso_pkg::REQ_INSERT) begin
      if (sel ? in_b(v) : in_a(v)) begin
        want_q.push_back({isso_pkg::ST_PRESENT, v, 1'b1});
      end else if ((sel ? cnt_b : cnt_a) >= CAPACITY) begin
        want_q.push_back({isso_pkg::ST_FULL, v, 1'b1});
      end else begin
        if (sel) begin mirror_b[cnt_b] = v; cnt_b++; end
        else begin mirror_a[cnt_a] = v; cnt_a++; end
        want_q.push_back({isso_pkg::ST_INSERTED, v, 1'b1});
      end
    end else if (rq == isso_pkg::REQ_DELETE) begin
      if (sel) begin
        for (int i = 0; i < cnt_b; i++) if (pos < 0 && mirror_b[i] == v) pos = i;
        if (pos >= 0) begin
          for (int i = pos; i + 1 < cnt_b; i++) mirror_b[i] = mirror_b[i+1];
          cnt_b--;
        end
      end else begin
        for (int i = 0; i < cnt_a; i++) if (pos < 0 && mirror_a[i] == v) pos = i;
        if (pos >= 0) begin
          for (int i = pos; i + 1 < cnt_a; i++) mirror_a[i] = mirror_a[i+1];
          cnt_a--;
        end
      end
      want_q.push_back({(pos >= 0) ? isso_pkg::ST_DELETED : isso_pkg::ST_NOTFOUND,
                        v, 1'b1});
    end else if (rq <= isso_pkg::REQ_DIFF) begin
      for (int i = 0; i < cnt_a; i++) begin
        inb = in_b(mirror_a[i]);
        if (rq == isso_pkg::REQ_UNION || (rq == isso_pkg::REQ_INTER && inb) ||
            (rq == isso_pkg::REQ_DIFF && !inb)) begin
          want_q.push_back({isso_pkg::ST_ELEMENT, mirror_a[i], 1'b0});
          n++;
        end
      end
      if (rq == isso_pkg::REQ_UNION) begin
        for (int i = 0; i < cnt_b; i++) begin
          if (!in_a(mirror_b[i])) begin
            want_q.push_back({isso_pkg::ST_ELEMENT, mirror_b[i], 1'b0});
            n++;
          end
        end
      end
      if (n == 0) begin
        want_q.push_back({isso_pkg::ST_EMPTY, 32'd0, 1'b1});
      end else begin
        r = want_q.pop_back();
        r.last = 1'b1;
        want_q.push_back(r);
      end
    end
  endtask

  // Watch both channels on each edge.
  always @(posedge clk) begin
    result_t w;
    if (rst) begin
      cnt_a = 0;
      cnt_b = 0;
      fail_count <= 0;
      want_q.delete();
    end else begin
      if (in_valid && in_ready) predict_request(req_type, set_sel, value);
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          $error("unexpected result transaction: status %0d element %0d", status, element);
          fail_count <= fail_count + 1;
        end else begin
          w = want_q.pop_front();
          if (status !== w.status) begin
            $error("status: expected %0d actual %0d", w.status, status);
            fail_count <= fail_count + 1;
          end else if (element !== w.element) begin
            $error("element: expected %0d actual %0d", $signed(w.element), element);
            fail_count <= fail_count + 1;
          end else if (last !== w.last) begin
            $error("last: expected %0d actual %0d", w.last, last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### sim/tb_integer_set_store_with_set_ops.sv
// Testbench top: drives requests and backpressure, reports the verdict.
`timescale 1ns / 1ps
module tb_integer_set_store_with_set_ops;
  localparam int Cap = 16;
  localparam int RandItems = 350;
  localparam int CycleLimit = 400000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         req_type;
  logic               set_sel;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         status;
  logic signed [31:0] element;
  logic               last;
  int                 fail_count;
  int                 pending;
  int                 cycles;
  bit                 long_hold;
  logic [31:0]        pool [8];

  integer_set_store_with_set_ops #(.CAPACITY(Cap)) u_dut (.*);

  isso_checker #(.CAPACITY(Cap)) u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Cycle limit watchdog.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stall pattern, plus one long hold-off on request.
  initial begin
    out_ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
      case ($urandom_range(0, 3))
        0: out_ready <= 1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Present one transaction and hold it until accepted.
  task automatic send(logic [2:0] rq, logic sel, logic [31:0] v);
    in_valid <= 1;
    req_type <= rq;
    set_sel  <= sel;
    value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pick_value(output logic [31:0] v);
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
      default: v = pool[$urandom_range(0, 7)];
    endcase
  endtask

  initial begin
    logic [31:0] v;
    logic [2:0]  rq;
    int          burst;
    bit          drained;
    rst = 1;
    in_valid = 0;
    req_type = isso_pkg::REQ_INSERT;
    set_sel = 0;
    value = 0;
    long_hold = 0;
    drained = 0;
    for (int i = 0; i < 8; i++) pool[i] = $urandom;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty ops, extremes, duplicates, missing deletes, fill to full.
    send(isso_pkg::REQ_UNION, 0, 0);
    send(isso_pkg::REQ_INTER, 0, 0);
    send(isso_pkg::REQ_DIFF, 1, 0);
    send(isso_pkg::REQ_DELETE, 0, 32'h8000_0000);
    send(isso_pkg::REQ_INSERT, 0, 32'h8000_0000);
    send(isso_pkg::REQ_INSERT, 0, 32'h7fff_ffff);
    send(isso_pkg::REQ_INSERT, 0, 32'h8000_0000);
    send(isso_pkg::REQ_INSERT, 1, 32'h7fff_ffff);
    send(isso_pkg::REQ_INSERT, 1, 32'hffff_ffff);
    send(3'd5, 1, 32'h1234);
    send(3'd7, 0, 32'hffff_ffff);
    send(isso_pkg::REQ_UNION, 0, 0);
    send(isso_pkg::REQ_INTER, 1, 0);
    send(isso_pkg::REQ_DIFF, 0, 0);
    for (int i = 0; i < Cap; i++) send(isso_pkg::REQ_INSERT, 0, i);
    send(isso_pkg::REQ_INSERT, 0, 32'h5555_aaaa);
    send(isso_pkg::REQ_DELETE, 0, 32'h7fff_ffff);
    send(isso_pkg::REQ_DELETE, 1, 32'h1234);
    for (int i = 0; i < Cap; i++) send(isso_pkg::REQ_INSERT, 1, i + 8);
    send(isso_pkg::REQ_UNION, 1, 0);
    send(isso_pkg::REQ_INTER, 0, 0);
    send(isso_pkg::REQ_DIFF, 0, 0);

    // Long receiver hold-off while the sender keeps offering.
    long_hold = 1;
    for (int i = 0; i < 12; i++) send(isso_pkg::REQ_UNION, 0, 0);

    // Random bursts with gaps.
    for (int n = 0; n < RandItems; ) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && n < RandItems; k++) begin
        pick_value(v);
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: rq = isso_pkg::REQ_INSERT;
          8, 9, 10, 11, 12: rq = isso_pkg::REQ_DELETE;
          13, 14: rq = isso_pkg::REQ_UNION;
          15, 16: rq = isso_pkg::REQ_INTER;
          17, 18: rq = isso_pkg::REQ_DIFF;
          default: rq = 3'($urandom_range(5, 7));
        endcase
        send(rq, 1'($urandom_range(0, 1)), v);
        if (rq <= isso_pkg::REQ_DIFF) n++;
      end
      in_valid <= 0;
      if (!drained && n >= RandItems / 2) begin
        // Sender waits for the block to drain completely.
        drained = 1;
        do @(posedge clk); while (pending != 0);
      end else begin
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end
    end
    in_valid <= 0;

    do @(posedge clk); while (pending != 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

### integer_set_store_with_set_ops.f
src/isso_pkg.sv
src/isso_cell.sv
src/isso_chain.sv
src/integer_set_store_with_set_ops.sv
sim/isso_checker.sv
sim/tb_integer_set_store_with_set_ops.sv
